FILE: rtl/cds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_pkg
// shared types, constants and helper functions of the cone direction sampler
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam int RAND_BITS     = 24;
   localparam int OUT_FRAC_BITS = 22;
   localparam int OUT_BITS      = OUT_FRAC_BITS + 2;
   localparam int STM_BITS      = 24;
   localparam int CORDIC_STEPS  = 30;
   localparam int SQRT_STEPS    = 32;
   localparam int CORDIC_CELLS  = 32;

   localparam logic [STM_BITS-1:0] STM_RESET   = 24'd78014;
   localparam logic [31:0]         CORDIC_GAIN = 32'h9B74EDA8;

   // input transfer payload
   typedef struct packed {
      logic [RAND_BITS-1:0] rand_phi;
      logic [RAND_BITS-1:0] rand_radius;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic signed [OUT_BITS-1:0] dir_x;
      logic signed [OUT_BITS-1:0] dir_y;
      logic signed [OUT_BITS-1:0] dir_z;
   } rsp_type;

   // digit-by-digit square root state
   typedef struct packed {
      logic [63:0] n;
      logic [63:0] res;
   } sqrt_type;

   // rotation state, angle in turns
   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [33:0] z;
      logic [1:0]         quad;
   } cordic_type;

   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   // clamp to +/-1.0 in Q2.32
   function automatic logic signed [33:0] clamp_one(input logic signed [35:0] v);
      logic signed [35:0] lim;
      lim = 36'sh1_0000_0000;
      if (v > lim) begin
         return 34'sh1_0000_0000;
      end else if (v < -lim) begin
         return -34'sh1_0000_0000;
      end
      return v[33:0];
   endfunction

   // magnitude product (Q1.64) rounded to the output grid, clamped, signed
   function automatic logic signed [OUT_BITS-1:0] round_out(input logic [64:0] p,
                                                            input logic neg);
      logic [63:0] m;
      logic [63:0] r;
      logic [63:0] lim;
      m   = p[64:1];
      r   = (m + (64'd1 << (62 - OUT_FRAC_BITS))) >> (63 - OUT_FRAC_BITS);
      lim = 64'd1 << OUT_FRAC_BITS;
      if (r > lim) begin
         r = lim;
      end
      return neg ? -(OUT_BITS'(r)) : OUT_BITS'(r);
   endfunction

endpackage

FILE: rtl/cds_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_sqrt_cell
// one registered step of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
module cds_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  logic [4:0]        step,
   input  cds_pkg::sqrt_type sq_in,
   output cds_pkg::sqrt_type sq_ff
);
   import cds_pkg::*;

   logic [63:0] bit_val;
   logic [63:0] trial;
   sqrt_type    sq_nxt_in;

   assign bit_val = 64'd1 << (6'd62 - {step, 1'b0});
   assign trial   = sq_in.res + bit_val;

   always_comb begin
      if (sq_in.n >= trial) begin
         sq_nxt_in.n   = sq_in.n - trial;
         sq_nxt_in.res = (sq_in.res >> 1) + bit_val;
      end else begin
         sq_nxt_in.n   = sq_in.n;
         sq_nxt_in.res = sq_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_nxt_in;
      end
   end

endmodule

FILE: rtl/cds_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_cordic_cell
// one registered rotation step, steps past the last one pass through
// ----------------------------------------------------------------------------
module cds_cordic_cell (
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          step,
   input  cds_pkg::cordic_type cr_in,
   output cds_pkg::cordic_type cr_ff
);
   import cds_pkg::*;

   logic signed [35:0] dx;
   logic signed [35:0] dy;
   logic signed [33:0] da;
   cordic_type         cr_nxt_in;

   assign dx = cr_in.y >>> step;
   assign dy = cr_in.x >>> step;
   assign da = $signed({2'b00, atan_turns(step)});

   always_comb begin
      cr_nxt_in = cr_in;
      if (step < 5'(CORDIC_STEPS)) begin
         if (cr_in.z >= 0) begin
            cr_nxt_in.x = cr_in.x - dx;
            cr_nxt_in.y = cr_in.y + dy;
            cr_nxt_in.z = cr_in.z - da;
         end else begin
            cr_nxt_in.x = cr_in.x + dx;
            cr_nxt_in.y = cr_in.y - dy;
            cr_nxt_in.z = cr_in.z + da;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cr_ff <= cr_nxt_in;
      end
   end

endmodule

FILE: rtl/cone_direction_sampler.sv
`timescale 1ns / 1ps
// throughput: one direction per cycle while the result side is not stalled
// the result register holds while it is valid and rsp_stall is high; the chain keeps filling
// until a finished result reaches the stage in front of it
// reset (synchronous) empties every stage and loads the half-angle default
// ----------------------------------------------------------------------------
// cone_direction_sampler
// uniform cone direction sampler: two square-root cell chains, a rotation
// cell chain and multiply stages produce a unit ray direction per transfer
// ----------------------------------------------------------------------------
module cone_direction_sampler (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cds_pkg::req_type               req_data,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cds_pkg::rsp_type               rsp_data,
   // half-angle register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cds_pkg::STM_BITS-1:0]   csr_wdata
);
   import cds_pkg::*;

   // stage map: A chain (radius sqrt + rotation), B1, B2, C chain, D1, result
   localparam int NA = SQRT_STEPS;
   localparam int NC = SQRT_STEPS;

   // ------------------------------------------------------------------------
   // half-angle register, always writable
   // ------------------------------------------------------------------------
   logic [STM_BITS-1:0] stm_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stm_ff <= STM_RESET;
      end else if (csr_valid && csr_ready) begin
         stm_ff <= csr_wdata;
      end
   end

   // ------------------------------------------------------------------------
   // flow control: the whole chain moves together unless the result register
   // is blocked and the stage in front of it holds a result
   // ------------------------------------------------------------------------
   logic          adv;
   logic          out_load;
   logic [NA-1:0] va_ff;
   logic          vb1_ff;
   logic          vb2_ff;
   logic [NC-1:0] vc_ff;
   logic          vd1_ff;
   logic          rsp_valid_ff;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_load || !vd1_ff;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= '0;
         vb1_ff       <= 1'b0;
         vb2_ff       <= 1'b0;
         vc_ff        <= '0;
         vd1_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            va_ff  <= {va_ff[NA-2:0], req_valid};
            vb1_ff <= va_ff[NA-1];
            vb2_ff <= vb1_ff;
            vc_ff  <= {vc_ff[NC-2:0], vb2_ff};
            vd1_ff <= vc_ff[NC-1];
         end
         if (out_load) begin
            rsp_valid_ff <= vd1_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // chain A: sqrt of the radius draw beside the azimuth rotation
   // ------------------------------------------------------------------------
   logic [31:0] u1;
   logic [31:0] u2;
   sqrt_type    sqa   [0:NA];
   cordic_type  cor   [0:CORDIC_CELLS];

   assign u1 = 32'(req_data.rand_phi) << (32 - RAND_BITS);
   assign u2 = 32'(req_data.rand_radius) << (32 - RAND_BITS);

   assign sqa[0].n   = {u2, 32'd0};
   assign sqa[0].res = 64'd0;

   assign cor[0].x    = $signed({4'd0, CORDIC_GAIN});
   assign cor[0].y    = 36'sd0;
   assign cor[0].z    = $signed({4'd0, u1[29:0]});
   assign cor[0].quad = u1[31:30];

   for (genvar i = 0; i < NA; i++) begin : g_chain_a
      cds_sqrt_cell u_sqrt (
         .clock (clock),
         .en    (adv),
         .step  (5'(i)),
         .sq_in (sqa[i]),
         .sq_ff (sqa[i+1])
      );
   end

   for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_chain_rot
      cds_cordic_cell u_rot (
         .clock (clock),
         .en    (adv),
         .step  (5'(i)),
         .cr_in (cor[i]),
         .cr_ff (cor[i+1])
      );
   end

   // quadrant fold of the rotation result
   logic signed [35:0] sn_raw;
   logic signed [35:0] cs_raw;
   cordic_type         cor_end;

   assign cor_end = cor[CORDIC_CELLS];

   always_comb begin
      unique case (cor_end.quad)
         2'd0: begin
            sn_raw = cor_end.y;
            cs_raw = cor_end.x;
         end
         2'd1: begin
            sn_raw = cor_end.x;
            cs_raw = -cor_end.y;
         end
         2'd2: begin
            sn_raw = -cor_end.y;
            cs_raw = -cor_end.x;
         end
         default: begin
            sn_raw = -cor_end.x;
            cs_raw = cor_end.y;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // B1: s = sin_theta_max * r ; B2: s^2
   // ------------------------------------------------------------------------
   logic [55:0]        prod_s;
   logic [31:0]        s_b1_ff;
   logic signed [33:0] sn_b1_ff;
   logic signed [33:0] cs_b1_ff;
   logic [63:0]        prod_s2;
   logic [31:0]        s2_b2_ff;

   assign prod_s  = 56'(stm_ff) * 56'(sqa[NA].res[31:0]);
   assign prod_s2 = 64'(s_b1_ff) * 64'(s_b1_ff);

   // side lines of chain C, index 0 is the B2 register
   logic [31:0]        s_ln  [0:NC];
   logic signed [33:0] sn_ln [0:NC];
   logic signed [33:0] cs_ln [0:NC];
   logic               zr_ln [0:NC];

   always_ff @(posedge clock) begin
      if (adv) begin
         s_b1_ff  <= prod_s[55:24];
         sn_b1_ff <= clamp_one(sn_raw);
         cs_b1_ff <= clamp_one(cs_raw);
         s2_b2_ff <= prod_s2[63:32];
         s_ln[0]  <= s_b1_ff;
         sn_ln[0] <= sn_b1_ff;
         cs_ln[0] <= cs_b1_ff;
         // zero s^2 marks an exact unit cosine
         zr_ln[0] <= (prod_s2[63:32] == 32'd0);
      end
   end

   // ------------------------------------------------------------------------
   // chain C: c = sqrt(1 - s^2), zero s^2 gives exactly one
   // ------------------------------------------------------------------------
   logic [32:0] one_minus;
   sqrt_type    sqc [0:NC];

   assign one_minus  = 33'h1_0000_0000 - 33'(s2_b2_ff);
   assign sqc[0].n   = {one_minus[31:0], 32'd0};
   assign sqc[0].res = 64'd0;

   for (genvar i = 0; i < NC; i++) begin : g_chain_c
      cds_sqrt_cell u_sqrt (
         .clock (clock),
         .en    (adv),
         .step  (5'(i)),
         .sq_in (sqc[i]),
         .sq_ff (sqc[i+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            s_ln[i+1]  <= s_ln[i];
            sn_ln[i+1] <= sn_ln[i];
            cs_ln[i+1] <= cs_ln[i];
            zr_ln[i+1] <= zr_ln[i];
         end
      end
   end

   // ------------------------------------------------------------------------
   // D1: output products and rounded cosine of the off-axis angle
   // ------------------------------------------------------------------------
   logic [32:0]         c_val;
   logic [33:0]         cy_sum;
   logic [32:0]         mag_x;
   logic [32:0]         mag_z;
   logic [64:0]         px_ff;
   logic [64:0]         pz_ff;
   logic                negx_ff;
   logic                negz_ff;
   logic [OUT_BITS-1:0] cy_ff;

   assign c_val  = zr_ln[NC] ? 33'h1_0000_0000 : sqc[NC].res[32:0];
   assign cy_sum = (34'(c_val) + (34'd1 << (31 - OUT_FRAC_BITS))) >> (32 - OUT_FRAC_BITS);
   assign mag_x  = sn_ln[NC][33] ? 33'(-sn_ln[NC]) : sn_ln[NC][32:0];
   assign mag_z  = cs_ln[NC][33] ? 33'(-cs_ln[NC]) : cs_ln[NC][32:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff   <= 65'(s_ln[NC]) * 65'(mag_x);
         pz_ff   <= 65'(s_ln[NC]) * 65'(mag_z);
         negx_ff <= sn_ln[NC][33];
         negz_ff <= cs_ln[NC][33];
         cy_ff   <= OUT_BITS'(cy_sum);
      end
   end

   // ------------------------------------------------------------------------
   // result register: rounding, clamp to +/-1, sign
   // ------------------------------------------------------------------------
   rsp_type             rsp_data_ff;
   logic [OUT_BITS-1:0] cy_lim;

   assign cy_lim = (cy_ff > (OUT_BITS'(1) << OUT_FRAC_BITS)) ?
                   (OUT_BITS'(1) << OUT_FRAC_BITS) : cy_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.dir_x <= round_out(px_ff, negx_ff);
         rsp_data_ff.dir_y <= -$signed(cy_lim);
         rsp_data_ff.dir_z <= round_out(pz_ff, negz_ff);
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   // the input side only stalls when a finished result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && vd1_ff))
      else $error("input stalled without a blocked result");

   // a blocked result with a result behind it freezes the chain
   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && vd1_ff) |=> vd1_ff)
      else $error("result lost behind a blocked output");

   // dir_y is never positive
   a_dir_y_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.dir_y[OUT_BITS-1] || (rsp_data.dir_y == '0)))
      else $error("positive dir_y");

   // nothing comes out of an empty chain after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

FILE: tb/cone_direction_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_direction_sampler_tb
// self-checking bench: a queue-fed driver pushes random-fraction pairs, a
// monitor compares each direction against a fixed-point predictor, and the
// half-angle register is rewritten between phases while the pipe is empty
// ----------------------------------------------------------------------------
module cone_direction_sampler_tb;
   import cds_pkg::*;

   localparam int LATENCY  = 68;
   localparam int WATCHDOG = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [STM_BITS-1:0] csr_wdata = '0;

   always #2 clock = ~clock;

   cone_direction_sampler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   req_type pending_rays[$];
   rsp_type expected_dirs[$];
   logic [STM_BITS-1:0] half_angle_sin = STM_RESET;
   int  errors = 0;
   int  idle_cycles = 0;

   localparam logic [31:0] ATAN_TAB [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

   // digit-by-digit integer square root
   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint clip_unit(input longint v);
      longint one;
      one = 64'sd1 <<< 32;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   // s (Q0.32) times trig (Q2.32) rounded onto the Q2.22 grid, ties away
   function automatic logic signed [OUT_BITS-1:0] scaled_comp(input logic [63:0] s,
                                                              input longint t);
      logic [63:0] mag, m;
      longint r, lim;
      mag = (t < 0) ? 64'(-t) : 64'(t);
      m   = (s * mag) >> 1;
      r   = longint'((m + (64'd1 << (62 - OUT_FRAC_BITS))) >> (63 - OUT_FRAC_BITS));
      if (t < 0) r = -r;
      lim = 64'sd1 <<< OUT_FRAC_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[OUT_BITS-1:0];
   endfunction

   function automatic rsp_type cone_direction(input req_type rq,
                                              input logic [STM_BITS-1:0] stm);
      logic [63:0] u1, u2, r, s, s2, c;
      longint x, y, z, dx, dy, sn, cs, cy, lim;
      logic [1:0] quad;
      rsp_type o;
      u1 = 64'(rq.rand_phi) << (32 - RAND_BITS);
      u2 = 64'(rq.rand_radius) << (32 - RAND_BITS);
      r  = int_sqrt(u2 << 32);
      s  = (64'(stm) * r) >> STM_BITS;
      s2 = (s * s) >> 32;
      if (s2 == 0) c = 64'd1 << 32;
      else c = int_sqrt(((64'd1 << 32) - s2) << 32);
      // rotation over the low 30 bits, quadrant from the top two
      quad = u1[31:30];
      z = longint'(u1[29:0]);
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
         end
      end
      case (quad)
         2'd0: begin sn = y;  cs = x;  end
         2'd1: begin sn = x;  cs = -y; end
         2'd2: begin sn = -y; cs = -x; end
         default: begin sn = -x; cs = y; end
      endcase
      sn = clip_unit(sn);
      cs = clip_unit(cs);
      cy = longint'((c + (64'd1 << (31 - OUT_FRAC_BITS))) >> (32 - OUT_FRAC_BITS));
      lim = 64'sd1 <<< OUT_FRAC_BITS;
      if (cy > lim) cy = lim;
      cy = -cy;
      o.dir_x = scaled_comp(s, sn);
      o.dir_y = cy[OUT_BITS-1:0];
      o.dir_z = scaled_comp(s, cs);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // stall as seen at the last rising edge, so the driver knows what was taken
   logic req_stall_q = 1'b1;
   int   stall_left = 0;
   bit   stall_phase = 1'b0;

   // driver: new transfer offered at the falling edge once the previous was taken
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            // previous transfer accepted on the last rising edge
            if (pending_rays.size() > 0 && req_gap == 0 && gap_len() == 0) begin
               req_data  <= pending_rays.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               req_gap   <= gap_len();
            end
         end else if (!req_valid) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
            end else if (pending_rays.size() > 0) begin
               req_data  <= pending_rays.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_stall_q <= req_stall;
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                   || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      // predict on every accepted input transfer
      if (!reset && req_valid && !req_stall)
         expected_dirs.push_back(cone_direction(req_data, half_angle_sin));
      if (!reset && csr_valid && csr_ready)
         half_angle_sin <= csr_wdata;
   end

   // monitor: compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dirs.size() == 0) begin
            $display("unexpected result transfer at %0t", $realtime);
            errors++;
         end else begin
            want = expected_dirs.pop_front();
            if (rsp_data.dir_x !== want.dir_x)
               report_mismatch("dir_x", rsp_data.dir_x, want.dir_x);
            if (rsp_data.dir_y !== want.dir_y)
               report_mismatch("dir_y", rsp_data.dir_y, want.dir_y);
            if (rsp_data.dir_z !== want.dir_z)
               report_mismatch("dir_z", rsp_data.dir_z, want.dir_z);
         end
      end
   end

   // result-side back-pressure, with calm stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_phase <= ($urandom_range(9) < 7);
         stall_left  <= gap_len() + $urandom_range(0, 6);
         rsp_stall   <= stall_phase ? 1'b0 : ($urandom_range(1) == 1);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic queue_ray(input logic [RAND_BITS-1:0] a, input logic [RAND_BITS-1:0] b);
      req_type t;
      t.rand_phi    = a;
      t.rand_radius = b;
      pending_rays.push_back(t);
   endtask

   task automatic drain_pipe();
      while (pending_rays.size() > 0 || req_valid || expected_dirs.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_half_angle(input logic [STM_BITS-1:0] v);
      @(negedge clock);
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_rays(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9);
         // mostly full-range draws, some edge values mixed in
         if (k < 7) begin
            queue_ray(RAND_BITS'($urandom), RAND_BITS'($urandom));
         end else if (k == 7) begin
            queue_ray(RAND_BITS'($urandom),
                      RAND_BITS'({RAND_BITS{1'b1}} - $urandom_range(3)));
         end else if (k == 8) begin
            queue_ray(RAND_BITS'($urandom_range(3) << 22), RAND_BITS'($urandom_range(3)));
         end else begin
            queue_ray({2'($urandom_range(3)), 22'h3FFFFF}, RAND_BITS'($urandom));
         end
      end
   endtask

   logic [STM_BITS-1:0] angle_set [6] = '{24'hFFFFFF, 24'd0, 24'd1,
                                          24'h800000, 24'h000100, 24'hB504F3};

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: field extremes and quadrant corners under the reset angle
      queue_ray('0, '0);
      queue_ray({RAND_BITS{1'b1}}, {RAND_BITS{1'b1}});
      queue_ray(24'h400000, {RAND_BITS{1'b1}});
      queue_ray(24'h800000, 24'h800000);
      queue_ray(24'hC00000, 24'h000001);
      queue_ray(24'h3FFFFF, {RAND_BITS{1'b1}});
      drain_pipe();
      // full half-angle and zero register
      write_half_angle(24'hFFFFFF);
      queue_ray('0, {RAND_BITS{1'b1}});
      queue_ray(24'h200000, {RAND_BITS{1'b1}});
      queue_ray(24'hAAAAAA, 24'h555555);
      queue_ray(24'h555555, 24'hAAAAAA);
      queue_ray(24'hE00000, '0);
      drain_pipe();
      write_half_angle(24'd0);
      queue_ray(24'h123456, {RAND_BITS{1'b1}});
      queue_ray({RAND_BITS{1'b1}}, 24'h654321);
      drain_pipe();
      // random phases over several angles, extremes included
      for (int p = 0; p < 6; p++) begin
         write_half_angle(p == 5 ? STM_BITS'($urandom) : angle_set[p]);
         random_rays(140);
         drain_pipe();
      end
      write_half_angle(STM_RESET);
      random_rays(20);
      drain_pipe();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: cone_direction_sampler.f
rtl/cds_pkg.sv
rtl/cds_sqrt_cell.sv
rtl/cds_cordic_cell.sv
rtl/cone_direction_sampler.sv
tb/cone_direction_sampler_tb.sv
